### rtl/ushpf_pkg.sv
`timescale 1ns / 1ps

package ushpf_pkg;

	// descriptor type codes
	localparam logic [7:0] TYPE_INTERFACE = 8'h04;
	localparam logic [7:0] TYPE_ENDPOINT  = 8'h05;
	localparam logic [7:0] TYPE_HID       = 8'h21;

	// interface class codes
	localparam logic [7:0] CLASS_HID      = 8'h03;
	localparam logic [7:0] SUBCLASS_BOOT  = 8'h01;
	localparam logic [7:0] PROTOCOL_MOUSE = 8'h02;

	// length and size rules
	localparam logic [15:0] TABLET_REPORT_LEN = 16'd74;
	localparam logic [10:0] TABLET_MIN_PACKET = 11'd5;
	localparam logic [7:0]  IFACE_MIN_LEN     = 8'd9;
	localparam logic [7:0]  HID_MIN_LEN       = 8'd9;
	localparam logic [7:0]  EP_MIN_LEN        = 8'd7;
	localparam logic [7:0]  MIN_DESC_LEN      = 8'd2;
	localparam logic [7:0]  LAST_CAPTURE_POS  = 8'd8;
	localparam int          CAPTURE_DEPTH     = 7;

	localparam logic [1:0] XFER_INTERRUPT = 2'b11;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_MOUSE  = 2'd1,
		KIND_TABLET = 2'd2
	} kind_t;

	// one input item
	typedef struct packed {
		logic [7:0] data_b;
		logic       last;
	} item_t;

	// chosen endpoint record
	typedef struct packed {
		logic [7:0]  iface;
		kind_t       kind;
		logic [7:0]  addr;
		logic [7:0]  attr;
		logic [10:0] mp;
		logic [7:0]  intv;
	} hit_t;

	// one result item
	typedef struct packed {
		logic found;
		hit_t hit;
	} res_t;

endpackage

### rtl/ushpf_in_stage.sv
`timescale 1ns / 1ps

module ushpf_in_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       data_byte,
	input  logic             block_end,
	input  logic             out_block,
	output logic             step,
	output ushpf_pkg::item_t item_s1
);
	import ushpf_pkg::*;

	logic valid_s1;
	logic accept;

	// hold only a final item whose result cannot leave yet
	assign in_stall = valid_s1 && item_s1.last && out_block;
	assign step     = valid_s1 && !in_stall;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.data_b <= data_byte;
			item_s1.last   <= block_end;
		end
	end

endmodule

### rtl/ushpf_walker.sv
`timescale 1ns / 1ps

module ushpf_walker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  ushpf_pkg::item_t item_s1,
	input  logic [10:0]      limit,
	output logic             res_valid,
	output ushpf_pkg::res_t  res
);
	import ushpf_pkg::*;

	logic [7:0] pos_q, size_q, code_q, iface_q;
	logic       hid_q, halt_q, hit_valid_q;
	kind_t      kind_q;
	hit_t       hit_q;
	logic [7:0] cap_q [CAPTURE_DEPTH];

	logic [7:0] pos_n, size_n, code_n, iface_n;
	logic       hid_n, halt_n, hit_valid_n;
	kind_t      kind_n;
	hit_t       hit_n;
	logic [7:0] cap_n [CAPTURE_DEPTH];

	logic        cap_wr;
	logic [2:0]  cap_idx;
	logic        done;
	logic [7:0]  b;
	logic [10:0] mp;
	logic [15:0] rlen;
	logic        size_ok, fits;

	assign b       = item_s1.data_b;
	assign cap_idx = 3'(pos_q - 8'd2);

	// one walk step plus decode of a finished descriptor
	always_comb begin
		cap_wr      = 1'b0;
		done        = 1'b0;
		pos_n       = pos_q;
		size_n      = size_q;
		code_n      = code_q;
		iface_n     = iface_q;
		hid_n       = hid_q;
		kind_n      = kind_q;
		halt_n      = halt_q;
		hit_valid_n = hit_valid_q;
		hit_n       = hit_q;

		if (!halt_q) begin
			if (pos_q == 8'd0) begin
				size_n = b;
				if (b < MIN_DESC_LEN) begin
					halt_n = 1'b1;
				end else begin
					pos_n = 8'd1;
				end
			end else begin
				if (pos_q == 8'd1) begin
					code_n = b;
				end else if (pos_q <= LAST_CAPTURE_POS) begin
					cap_wr = 1'b1;
				end
				if (({1'b0, pos_q} + 9'd1) >= {1'b0, size_q}) begin
					done  = 1'b1;
					pos_n = 8'd0;
				end else begin
					pos_n = pos_q + 8'd1;
				end
			end
		end

		// captured bytes with the current byte forwarded
		for (int i = 0; i < CAPTURE_DEPTH; i++) begin
			cap_n[i] = (cap_wr && cap_idx == 3'(i)) ? b : cap_q[i];
		end

		mp      = {cap_n[3][2:0], cap_n[2]};
		rlen    = {cap_n[6], cap_n[5]};
		size_ok = (kind_q != KIND_TABLET) || (mp >= TABLET_MIN_PACKET);
		fits    = (limit == 11'd0) || (mp <= limit);

		if (done) begin
			if (code_n == TYPE_INTERFACE && size_q >= IFACE_MIN_LEN) begin
				iface_n = cap_n[0];
				hid_n   = (cap_n[3] == CLASS_HID);
				kind_n  = KIND_NONE;
				if (cap_n[3] == CLASS_HID && cap_n[4] == SUBCLASS_BOOT &&
						cap_n[5] == PROTOCOL_MOUSE) begin
					kind_n = KIND_MOUSE;
				end
			end else if (code_n == TYPE_HID && size_q >= HID_MIN_LEN) begin
				if (hid_q && kind_q == KIND_NONE && rlen == TABLET_REPORT_LEN) begin
					kind_n = KIND_TABLET;
				end
			end else if (code_n == TYPE_ENDPOINT && size_q >= EP_MIN_LEN) begin
				if (!hit_valid_q && kind_q != KIND_NONE && size_ok && fits &&
						cap_n[1][1:0] == XFER_INTERRUPT && cap_n[0][7]) begin
					hit_valid_n = 1'b1;
					hit_n.iface = iface_q;
					hit_n.kind  = kind_q;
					hit_n.addr  = cap_n[0];
					hit_n.attr  = cap_n[1];
					hit_n.mp    = mp;
					hit_n.intv  = cap_n[4];
				end
			end
		end

		res_valid = step && item_s1.last;
		res.found = hit_valid_n;
		res.hit   = hit_valid_n ? hit_n : '0;
	end

	// walk state, cleared after the final item of a block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			size_q      <= '0;
			code_q      <= '0;
			iface_q     <= '0;
			hid_q       <= 1'b0;
			kind_q      <= KIND_NONE;
			halt_q      <= 1'b0;
			hit_valid_q <= 1'b0;
			hit_q       <= '0;
		end else if (step) begin
			if (item_s1.last) begin
				pos_q       <= '0;
				size_q      <= '0;
				code_q      <= '0;
				iface_q     <= '0;
				hid_q       <= 1'b0;
				kind_q      <= KIND_NONE;
				halt_q      <= 1'b0;
				hit_valid_q <= 1'b0;
				hit_q       <= '0;
			end else begin
				pos_q       <= pos_n;
				size_q      <= size_n;
				code_q      <= code_n;
				iface_q     <= iface_n;
				hid_q       <= hid_n;
				kind_q      <= kind_n;
				halt_q      <= halt_n;
				hit_valid_q <= hit_valid_n;
				hit_q       <= hit_n;
			end
		end
	end

	// descriptor bytes two to eight
	always_ff @(posedge clk) begin
		if (step && cap_wr) begin
			cap_q[cap_idx] <= b;
		end
	end

endmodule

### rtl/usb_hid_pointer_endpoint_finder_top.sv
`timescale 1ns / 1ps
// the result register captures a result as the final item of its block is walked
// throughput: one item per cycle unless stalled, set by the combinational descriptor walk step
// the input register stalls only when a final item meets a result still held
// reset: asynchronous, active low; clears the walk state, the valid flags and
// sets the limit register limit_q to zero (no limit)

module usb_hid_pointer_endpoint_finder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        block_end,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found_flag,
	output logic [7:0]  owner_iface,
	output logic [1:0]  device_kind,
	output logic [7:0]  endpoint_address,
	output logic [7:0]  endpoint_attributes,
	output logic [10:0] max_packet,
	output logic [7:0]  poll_interval
);
	import ushpf_pkg::*;

	item_t       item_s1;
	logic        step;
	logic        res_valid;
	res_t        res;
	res_t        res_q;
	logic        out_valid_q;
	logic [10:0] limit_q;

	ushpf_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.block_end (block_end),
		.out_block (out_valid_q && out_stall),
		.step      (step),
		.item_s1   (item_s1)
	);

	ushpf_walker u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item_s1   (item_s1),
		.limit     (limit_q),
		.res_valid (res_valid),
		.res       (res)
	);

	// limit register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid           = out_valid_q;
	assign found_flag          = res_q.found;
	assign owner_iface         = res_q.hit.iface;
	assign device_kind         = res_q.hit.kind;
	assign endpoint_address    = res_q.hit.addr;
	assign endpoint_attributes = res_q.hit.attr;
	assign max_packet          = res_q.hit.mp;
	assign poll_interval       = res_q.hit.intv;

endmodule

### rtl/ushpf_checker.sv
`timescale 1ns / 1ps

module ushpf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        found_flag,
	input logic [7:0]  owner_iface,
	input logic [1:0]  device_kind,
	input logic [7:0]  endpoint_address,
	input logic [7:0]  endpoint_attributes,
	input logic [10:0] max_packet,
	input logic [7:0]  poll_interval
);
	import ushpf_pkg::*;

	// a held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found_flag) &&
		$stable(endpoint_address) && $stable(max_packet))
		else $error("result changed while stalled");

	// input stalls only behind a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with output free");

	// an empty result is all zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found_flag |-> owner_iface == 8'd0 &&
		device_kind == KIND_NONE && endpoint_address == 8'd0 &&
		endpoint_attributes == 8'd0 && max_packet == 11'd0 && poll_interval == 8'd0)
		else $error("empty result carries data");

	// a hit is an interrupt in endpoint of a marked interface
	a_hit_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found_flag |-> endpoint_address[7] &&
		endpoint_attributes[1:0] == XFER_INTERRUPT && device_kind != KIND_NONE)
		else $error("hit endpoint not interrupt in");

	// tablet endpoints carry a usable packet size
	a_tablet_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found_flag && device_kind == KIND_TABLET |->
		max_packet >= TABLET_MIN_PACKET)
		else $error("tablet packet size too small");

endmodule

bind usb_hid_pointer_endpoint_finder_top ushpf_checker u_ushpf_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.in_stall            (in_stall),
	.out_valid           (out_valid),
	.out_stall           (out_stall),
	.found_flag          (found_flag),
	.owner_iface         (owner_iface),
	.device_kind         (device_kind),
	.endpoint_address    (endpoint_address),
	.endpoint_attributes (endpoint_attributes),
	.max_packet          (max_packet),
	.poll_interval       (poll_interval)
);
